@@ src/usr_pkg.sv @@
package usr_pkg;

   // Configuration register widths and port shape
   localparam int CFG_LONG_BITS  = 24;
   localparam int CFG_SHORT_BITS = 16;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLL_PERIOD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_WIDTH    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD          = 3'd4;

   // Register reset values
   localparam logic [CFG_LONG_BITS-1:0]  POLL_PERIOD_RST   = 24'd90000;
   localparam logic [CFG_SHORT_BITS-1:0] START_TIMEOUT_RST = 16'd2300;
   localparam logic [CFG_SHORT_BITS-1:0] HIGH_TIMEOUT_RST  = 16'd900;
   localparam logic [CFG_SHORT_BITS-1:0] NEAR_WIDTH_RST    = 16'd580;
   localparam logic [CFG_LONG_BITS-1:0]  HOLD_RST          = 24'd700000;

   // Default timer widths
   localparam int LONG_TIMER_BITS_DEF  = 24;
   localparam int PULSE_TIMER_BITS_DEF = 16;

   // Trigger pulse shape in ticks
   localparam int TRIG_LOW_TICKS  = 2;
   localparam int TRIG_HIGH_TICKS = 10;

   // Result field widths
   localparam int DISTANCE_BITS = 11;
   localparam int WIDTH_BITS    = 16;

   // Event status codes
   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_MEASURED = 2'd1;
   localparam logic [1:0] ST_NO_ECHO  = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // Width to centimetres: multiply by a rounded-up reciprocal of 58.
   // With a 22-bit shift the error stays below one for any 16-bit width.
   localparam int CM_DIVISOR = 58;
   localparam int CM_SHIFT   = 22;
   localparam int CM_RECIP   = ((1 << CM_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
   localparam int PROD_BITS  = WIDTH_BITS + 17;

   typedef struct packed {
      logic [CFG_LONG_BITS-1:0]  poll_period_ticks;
      logic [CFG_SHORT_BITS-1:0] start_timeout_ticks;
      logic [CFG_SHORT_BITS-1:0] high_timeout_ticks;
      logic [CFG_SHORT_BITS-1:0] near_width_ticks;
      logic [CFG_LONG_BITS-1:0]  hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic                     trigger_level;
      logic                     near_flag;
      logic [DISTANCE_BITS-1:0] distance_cm;
      logic [WIDTH_BITS-1:0]    pulse_width;
      logic [1:0]               event_status;
   } rsp_data_type;

   function automatic logic [DISTANCE_BITS-1:0] width_to_cm(input logic [WIDTH_BITS-1:0] w);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(w) * PROD_BITS'(CM_RECIP);
      return prod[CM_SHIFT +: DISTANCE_BITS];
   endfunction

endpackage

@@ src/usr_if.sv @@
// Tick channel: one transaction per microsecond tick
interface usr_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink (input valid, input echo_level, output ready);
endinterface

// Result channel: one transaction per tick
interface usr_rsp_if
   import usr_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     trigger_level;
   logic                     near_flag;
   logic [DISTANCE_BITS-1:0] distance_cm;
   logic [WIDTH_BITS-1:0]    pulse_width;
   logic [1:0]               event_status;

   modport source (output valid, output trigger_level, output near_flag,
                   output distance_cm, output pulse_width, output event_status,
                   input ready);
   modport sink (input valid, input trigger_level, input near_flag,
                 input distance_cm, input pulse_width, input event_status,
                 output ready);
endinterface

@@ src/usr_core.sv @@
module usr_core
   import usr_pkg::*;
#(
   parameter int LONG_TIMER_BITS  = LONG_TIMER_BITS_DEF,
   parameter int PULSE_TIMER_BITS = PULSE_TIMER_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         echo_level,
   input  cfg_type      cfg,
   output rsp_data_type result
);

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
   localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
   localparam logic [2:0] PH_WAIT_RISE = 3'd3;
   localparam logic [2:0] PH_MEASURE   = 3'd4;

   localparam int LONG_CMP_BITS  =
      (LONG_TIMER_BITS > CFG_LONG_BITS) ? LONG_TIMER_BITS : CFG_LONG_BITS;
   localparam int PULSE_CMP_BITS =
      (PULSE_TIMER_BITS > CFG_SHORT_BITS) ? PULSE_TIMER_BITS : CFG_SHORT_BITS;

   logic [2:0]                  phase_ff, phase_in;
   logic [LONG_TIMER_BITS-1:0]  poll_elapsed_ff, poll_elapsed_in;
   logic [PULSE_TIMER_BITS-1:0] phase_elapsed_ff, phase_elapsed_in;
   logic                        near_seen_ff, near_seen_in;
   logic [LONG_TIMER_BITS-1:0]  near_age_ff, near_age_in;
   logic [LONG_TIMER_BITS-1:0]  age_at_poll_ff, age_at_poll_in;
   logic                        near_ff, near_in;
   logic [DISTANCE_BITS-1:0]    distance_ff, distance_in;
   logic [WIDTH_BITS-1:0]       width_ff, width_in;

   // One tick: start check, phase work, distance and near flag, saturating counters, then result
   always_comb begin
      logic [LONG_TIMER_BITS-1:0]  poll_v;
      logic [LONG_TIMER_BITS-1:0]  age_v;
      logic [PULSE_TIMER_BITS-1:0] pe_inc;
      logic                        trig;
      logic [1:0]                  status;
      logic                        finish;
      logic                        load_width;

      phase_in         = (phase_ff > PH_MEASURE) ? PH_IDLE : phase_ff;
      poll_v           = poll_elapsed_ff;
      age_v            = near_age_ff;
      phase_elapsed_in = phase_elapsed_ff;
      age_at_poll_in   = age_at_poll_ff;
      near_seen_in     = near_seen_ff;
      near_in          = near_ff;
      width_in         = width_ff;
      distance_in      = distance_ff;
      trig             = 1'b0;
      status           = ST_NONE;
      finish           = 1'b0;
      load_width       = 1'b0;

      // Start a measurement when the poll period is due
      if (phase_in == PH_IDLE &&
          (LONG_CMP_BITS'(poll_elapsed_ff) >= LONG_CMP_BITS'(cfg.poll_period_ticks) ||
           &poll_elapsed_ff)) begin
         poll_v           = '0;
         age_at_poll_in   = near_age_ff;
         phase_in         = PH_TRIG_LOW;
         phase_elapsed_in = '0;
      end

      pe_inc = (&phase_elapsed_in) ? phase_elapsed_in : phase_elapsed_in + 1'b1;

      case (phase_in)
         PH_TRIG_LOW: begin
            phase_elapsed_in = pe_inc;
            if (pe_inc >= PULSE_TIMER_BITS'(TRIG_LOW_TICKS)) begin
               phase_in         = PH_TRIG_HIGH;
               phase_elapsed_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            trig             = 1'b1;
            phase_elapsed_in = pe_inc;
            if (pe_inc >= PULSE_TIMER_BITS'(TRIG_HIGH_TICKS)) begin
               phase_in         = PH_WAIT_RISE;
               phase_elapsed_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               phase_in         = PH_MEASURE;
               phase_elapsed_in = '0;
            end else begin
               phase_elapsed_in = pe_inc;
               if (PULSE_CMP_BITS'(pe_inc) > PULSE_CMP_BITS'(cfg.start_timeout_ticks) ||
                   &pe_inc) begin
                  status           = ST_NO_ECHO;
                  phase_in         = PH_IDLE;
                  phase_elapsed_in = '0;
                  finish           = 1'b1;
               end
            end
         end
         PH_MEASURE: begin
            phase_elapsed_in = pe_inc;
            if (!echo_level) begin
               // Echo fell: record the width, note a near object
               status     = ST_MEASURED;
               width_in   = WIDTH_BITS'(pe_inc);
               load_width = 1'b1;
               if (width_in <= cfg.near_width_ticks) begin
                  near_seen_in   = 1'b1;
                  age_v          = poll_elapsed_ff;
                  age_at_poll_in = '0;
               end
               phase_in         = PH_IDLE;
               phase_elapsed_in = '0;
               finish           = 1'b1;
            end else if (PULSE_CMP_BITS'(pe_inc) > PULSE_CMP_BITS'(cfg.high_timeout_ticks) ||
                         &pe_inc) begin
               // Cut off: report the timeout as the width
               status           = ST_TOO_LONG;
               width_in         = cfg.high_timeout_ticks;
               load_width       = 1'b1;
               phase_in         = PH_IDLE;
               phase_elapsed_in = '0;
               finish           = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (load_width) begin
         distance_in = width_to_cm(width_in);
      end

      // Update the held near flag at the end of each measurement
      if (finish) begin
         near_in = near_seen_in &&
                   (LONG_CMP_BITS'(age_at_poll_in) <= LONG_CMP_BITS'(cfg.hold_ticks));
      end

      poll_elapsed_in = (&poll_v) ? poll_v : poll_v + 1'b1;
      near_age_in     = (&age_v) ? age_v : age_v + 1'b1;

      result.trigger_level = trig;
      result.near_flag     = near_in;
      result.distance_cm   = distance_in;
      result.pulse_width   = width_in;
      result.event_status  = status;
   end

   // Advance state once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         poll_elapsed_ff  <= '0;
         phase_elapsed_ff <= '0;
         near_seen_ff     <= 1'b0;
         near_age_ff      <= '0;
         age_at_poll_ff   <= '0;
         near_ff          <= 1'b0;
         distance_ff      <= '0;
         width_ff         <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         poll_elapsed_ff  <= poll_elapsed_in;
         phase_elapsed_ff <= phase_elapsed_in;
         near_seen_ff     <= near_seen_in;
         near_age_ff      <= near_age_in;
         age_at_poll_ff   <= age_at_poll_in;
         near_ff          <= near_in;
         distance_ff      <= distance_in;
         width_ff         <= width_in;
      end
   end

endmodule

@@ src/ultrasonic_ranger_with_near_hold.sv @@
// Ultrasonic echo ranger with near hold. Each transaction on req_chan is one
// microsecond tick carrying the sampled echo pin level; each tick yields exactly
// one transaction on rsp_chan with the trigger pin level for that tick, the held
// near flag, the last distance in centimetres, the last echo width in ticks and
// an event status (none, measured, echo never rose, echo too long). Throughput is
// one tick per clock cycle while rsp_chan does not stall; a taken tick is held in
// the input register, passes once through the step logic and lands in the result
// register, where it is held until rsp_chan accepts it. The step path holds one
// 16x17 multiply for the centimetre conversion. Configuration registers are
// written through csr_wr_en, csr_index and csr_wdata and take effect on the next
// tick processed.
module ultrasonic_ranger_with_near_hold
   import usr_pkg::*;
#(
   parameter int LONG_TIMER_BITS  = LONG_TIMER_BITS_DEF,
   parameter int PULSE_TIMER_BITS = PULSE_TIMER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   usr_req_if.sink                   req_chan,
   usr_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   logic         in_echo_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type step_result;
   logic         step;
   logic         req_fire;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_period_ticks   <= POLL_PERIOD_RST;
         cfg_ff.start_timeout_ticks <= START_TIMEOUT_RST;
         cfg_ff.high_timeout_ticks  <= HIGH_TIMEOUT_RST;
         cfg_ff.near_width_ticks    <= NEAR_WIDTH_RST;
         cfg_ff.hold_ticks          <= HOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POLL_PERIOD:   cfg_ff.poll_period_ticks   <= CFG_LONG_BITS'(csr_wdata);
            CSR_START_TIMEOUT: cfg_ff.start_timeout_ticks <= CFG_SHORT_BITS'(csr_wdata);
            CSR_HIGH_TIMEOUT:  cfg_ff.high_timeout_ticks  <= CFG_SHORT_BITS'(csr_wdata);
            CSR_NEAR_WIDTH:    cfg_ff.near_width_ticks    <= CFG_SHORT_BITS'(csr_wdata);
            CSR_HOLD:          cfg_ff.hold_ticks          <= CFG_LONG_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Handshake: process the held tick when the result register is free
   assign step           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !step);
   assign out_valid_in   = step || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_echo_ff <= req_chan.echo_level;
      end
      if (step) begin
         out_data_ff <= step_result;
      end
   end

   usr_core #(
      .LONG_TIMER_BITS  (LONG_TIMER_BITS),
      .PULSE_TIMER_BITS (PULSE_TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .echo_level (in_echo_ff),
      .cfg        (cfg_ff),
      .result     (step_result)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.trigger_level = out_data_ff.trigger_level;
   assign rsp_chan.near_flag     = out_data_ff.near_flag;
   assign rsp_chan.distance_cm   = out_data_ff.distance_cm;
   assign rsp_chan.pulse_width   = out_data_ff.pulse_width;
   assign rsp_chan.event_status  = out_data_ff.event_status;

endmodule

@@ src/usr_checker.sv @@
module usr_checker
   import usr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     trigger_level,
   input logic                     near_flag,
   input logic [DISTANCE_BITS-1:0] distance_cm,
   input logic [WIDTH_BITS-1:0]    pulse_width,
   input logic [1:0]               event_status
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(trigger_level) &&
      $stable(near_flag) && $stable(distance_cm) && $stable(pulse_width) &&
      $stable(event_status))
      else $error("result changed while stalled");

   // Drop any result after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A measurement never ends during the trigger pulse
   a_trig_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && trigger_level |-> event_status == ST_NONE)
      else $error("event reported while trigger high");

   // A finished measurement gives a distance within the sensor range
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_status == ST_MEASURED || event_status == ST_TOO_LONG)
      |-> distance_cm <= DISTANCE_BITS'(1129))
      else $error("distance out of range");

endmodule

bind ultrasonic_ranger_with_near_hold usr_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .trigger_level (rsp_chan.trigger_level),
   .near_flag     (rsp_chan.near_flag),
   .distance_cm   (rsp_chan.distance_cm),
   .pulse_width   (rsp_chan.pulse_width),
   .event_status  (rsp_chan.event_status)
);
